// ===== rtl/lbgf_pkg.sv =====
// ---------------------------------------------------------------------------
// LED bar graph fader package
// Shared constants, register indexes and the command word passed from the
// front (divider) to the back (LED emitter).
// ---------------------------------------------------------------------------
package lbgf_pkg;

    localparam int TIME_W   = 32;
    localparam int COLOR_W  = 32;
    localparam int CNT_W    = 5;
    localparam int IDX_W    = 4;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Number of LEDs that can be driven; the LED count is clamped to it where it is used.
    localparam int MAX_LEDS = 16;
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        CNT_W'((MAX_LEDS < 16) ? MAX_LEDS : 16);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_COLOR  = 2'd2;

    localparam logic [TIME_W-1:0]  RST_FULL_SCALE = 32'd1500000;
    localparam logic [CNT_W-1:0]   RST_LED_COUNT  = 5'd10;
    localparam logic [COLOR_W-1:0] RST_BAR_COLOR  = 32'h00FF0000;

    // Quotient of (time*count << 16) / full_scale has at most 21 bits.
    localparam int QUOT_W    = FRAC_W + CNT_W;
    localparam int DIV_STEPS = QUOT_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic               off;
        logic [CNT_W-1:0]   whole;
        logic [CNT_W-1:0]   n;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] fade;
    } cmd_t;

endpackage

// ===== rtl/lbgf_front.sv =====
// ---------------------------------------------------------------------------
// LED bar graph fader front end
// Accepts a time word, multiplies by the LED count and, unless full scale is zero
// or the time exceeds it, runs a restoring divide by the full-scale time, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lbgf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [lbgf_pkg::TIME_W-1:0]   time_ms,
    input  logic [lbgf_pkg::TIME_W-1:0]   full_scale_time,
    input  logic [lbgf_pkg::CNT_W-1:0]    led_count,
    input  logic [lbgf_pkg::COLOR_W-1:0]  bar_color,
    output logic                          cmd_push,
    input  logic                          cmd_full,
    output lbgf_pkg::cmd_t                cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

    state_t                          state_reg;
    logic [lbgf_pkg::TIME_W-1:0]     rem_reg;
    logic [lbgf_pkg::QUOT_W-1:0]     low_reg;
    logic [lbgf_pkg::QUOT_W-1:0]     q_reg;
    logic [lbgf_pkg::STEP_W-1:0]     step_reg;
    logic                            off_reg;
    logic [lbgf_pkg::CNT_W-1:0]      n_reg;

    logic [lbgf_pkg::CNT_W-1:0]      n_clamp;
    logic [36:0]                     prod;
    logic                            off_now;
    logic                            accept;
    logic [lbgf_pkg::TIME_W:0]       trial;
    logic [lbgf_pkg::TIME_W:0]       diff;
    logic                            ge;
    logic [lbgf_pkg::TIME_W-1:0]     rem_next;
    logic [lbgf_pkg::COLOR_W-1:0]    fade;
    logic [23:0]                     byte_prod [4];

    assign n_clamp = (led_count > lbgf_pkg::CNT_LIMIT) ? lbgf_pkg::CNT_LIMIT : led_count;
    assign prod    = {5'd0, time_ms} * {32'd0, n_clamp};
    assign off_now = (full_scale_time == '0) || (time_ms > full_scale_time);
    assign full    = (state_reg != ST_IDLE);
    assign accept  = push && !full;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign trial    = {rem_reg, low_reg[lbgf_pkg::QUOT_W-1]};
    assign ge       = (trial >= {1'b0, full_scale_time});
    assign diff     = trial - {1'b0, full_scale_time};
    assign rem_next = ge ? diff[lbgf_pkg::TIME_W-1:0] : trial[lbgf_pkg::TIME_W-1:0];

    // Each color byte scaled by the 0.16 fraction, truncated.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            byte_prod[k] = {16'd0, bar_color[8*k +: 8]} * {8'd0, q_reg[lbgf_pkg::FRAC_W-1:0]};
            fade[8*k +: 8] = byte_prod[k][23:16];
        end
    end

    assign cmd_push  = (state_reg == ST_DONE) && !cmd_full;
    assign cmd.off   = off_reg;
    assign cmd.whole = q_reg[lbgf_pkg::QUOT_W-1:lbgf_pkg::FRAC_W];
    assign cmd.n     = n_reg;
    assign cmd.color = bar_color;
    assign cmd.fade  = fade;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= off_now ? ST_DONE : ST_DIV;
                        step_reg  <= '0;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == lbgf_pkg::STEP_W'(lbgf_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            off_reg <= off_now;
            n_reg   <= n_clamp;
            // The quotient fits in 21 bits, so the top dividend bits start
            // out below the divisor.
            rem_reg <= {1'b0, prod[35:5]};
            low_reg <= {prod[4:0], 16'd0};
            q_reg   <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[lbgf_pkg::QUOT_W-2:0], 1'b0};
            q_reg   <= {q_reg[lbgf_pkg::QUOT_W-2:0], ge};
        end
    end

    // The lit part of the bar never exceeds the LED count.
    a_whole_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && !off_reg |-> (q_reg[lbgf_pkg::QUOT_W-1:lbgf_pkg::FRAC_W] <= n_reg))
        else $error("whole part exceeds LED count");

endmodule

// ===== rtl/lbgf_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// LED bar graph fader command queue
// Two-entry queue of frame commands between the divider and the emitter.
// ---------------------------------------------------------------------------
module lbgf_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lbgf_pkg::cmd_t  din,
    input  logic            pop,
    output logic            empty,
    output lbgf_pkg::cmd_t  dout
);

    localparam int PTR_W = $clog2(lbgf_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(lbgf_pkg::FIFO_DEPTH + 1);

    lbgf_pkg::cmd_t    mem [lbgf_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(lbgf_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(lbgf_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(lbgf_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(lbgf_pkg::FIFO_DEPTH))
        else $error("command queue count out of range");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("front wrote into a full command queue");

endmodule

// ===== rtl/lbgf_back.sv =====
// ---------------------------------------------------------------------------
// LED bar graph fader back end
// Takes one frame command and emits one color word per LED into an output
// register that the consumer drains.
// ---------------------------------------------------------------------------
module lbgf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  lbgf_pkg::cmd_t                cmd,
    output logic                          empty,
    input  logic                          pop,
    output logic [lbgf_pkg::IDX_W-1:0]    led_index,
    output logic [lbgf_pkg::COLOR_W-1:0]  led_color,
    output logic                          last
);

    lbgf_pkg::cmd_t                 cur_reg;
    logic                           active_reg;
    logic [lbgf_pkg::IDX_W-1:0]     idx_reg;
    logic                           out_valid_reg;
    logic [lbgf_pkg::IDX_W-1:0]     out_idx_reg;
    logic [lbgf_pkg::COLOR_W-1:0]   out_color_reg;
    logic                           out_last_reg;

    logic                           adv;
    logic                           emit_last;
    logic [lbgf_pkg::CNT_W-1:0]     idx_ext;
    logic [lbgf_pkg::COLOR_W-1:0]   color_next;

    assign cmd_pop   = !active_reg && !cmd_empty;
    assign adv       = active_reg && (!out_valid_reg || pop);
    assign idx_ext   = {1'b0, idx_reg};
    assign emit_last = ((idx_ext + 1'b1) == cur_reg.n);

    always_comb
    begin
        if (cur_reg.off)
        begin
            color_next = '0;
        end
        else if (idx_ext < cur_reg.whole)
        begin
            color_next = cur_reg.color;
        end
        else if (idx_ext == cur_reg.whole)
        begin
            color_next = cur_reg.fade;
        end
        else
        begin
            color_next = '0;
        end
    end

    assign empty     = !out_valid_reg;
    assign led_index = out_idx_reg;
    assign led_color = out_color_reg;
    assign last      = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                // A frame with no LEDs produces no words.
                active_reg <= (cmd.n != '0);
                idx_reg    <= '0;
            end
            else if (adv)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (emit_last)
                begin
                    active_reg <= 1'b0;
                end
            end

            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (adv)
        begin
            out_idx_reg   <= idx_reg;
            out_color_reg <= color_next;
            out_last_reg  <= emit_last;
        end
    end

    // Within a frame the LED positions come out in ascending order.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(pop && !empty && !last) && !empty |-> (led_index == $past(led_index) + 1'b1))
        else $error("LED index did not advance within a frame");

endmodule

// ===== rtl/led_bar_graph_fader.sv =====
// ---------------------------------------------------------------------------
// LED bar graph fader
// Turns a remaining time into one ARGB color word per LED of a bar graph.
// ---------------------------------------------------------------------------
// Path: an accepted time word goes through the bit-serial divider, the command
// queue and the output register before the first LED word appears.
// The divider takes no new time word until the last one's command is queued, and
// skips the division when the time is past full scale; the emitter gives one LED word
// per cycle while the consumer keeps popping, and fetches each frame command first.
// Reset clears all control state and loads the register defaults.
module led_bar_graph_fader (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lbgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbgf_pkg::COLOR_W-1:0]    cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [lbgf_pkg::TIME_W-1:0]     time_ms,
    output logic                            empty,
    input  logic                            pop,
    output logic [lbgf_pkg::IDX_W-1:0]      led_index,
    output logic [lbgf_pkg::COLOR_W-1:0]    led_color,
    output logic                            last
);

    logic [lbgf_pkg::TIME_W-1:0]   full_scale_reg;
    logic [lbgf_pkg::CNT_W-1:0]    led_count_reg;
    logic [lbgf_pkg::COLOR_W-1:0]  bar_color_reg;

    lbgf_pkg::cmd_t  front_cmd;
    lbgf_pkg::cmd_t  back_cmd;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= lbgf_pkg::RST_FULL_SCALE;
            led_count_reg  <= lbgf_pkg::RST_LED_COUNT;
            bar_color_reg  <= lbgf_pkg::RST_BAR_COLOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbgf_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_data;
                lbgf_pkg::CFG_LED_COUNT:  led_count_reg  <= cfg_data[lbgf_pkg::CNT_W-1:0];
                lbgf_pkg::CFG_BAR_COLOR:  bar_color_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    lbgf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .time_ms         (time_ms),
        .full_scale_time (full_scale_reg),
        .led_count       (led_count_reg),
        .bar_color       (bar_color_reg),
        .cmd_push        (q_push),
        .cmd_full        (q_full),
        .cmd             (front_cmd)
    );

    lbgf_cmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .din   (front_cmd),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (back_cmd)
    );

    lbgf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .cmd       (back_cmd),
        .empty     (empty),
        .pop       (pop),
        .led_index (led_index),
        .led_color (led_color),
        .last      (last)
    );

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// led_bar_graph_fader testbench
// Sends remaining-time words through the push/full side and checks every LED
// word on the pop/empty side against a frame predictor. The predictor keeps a
// shadow copy of the registers. It covers the register extremes, counts that
// saturate or are zero, a zero full scale, and random frames with random
// idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lbgf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [lbgf_pkg::IDX_W-1:0]   idx;
        logic [lbgf_pkg::COLOR_W-1:0] color;
        logic                         last;
    } led_word_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [lbgf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lbgf_pkg::COLOR_W-1:0]   cfg_data  = '0;
    logic                           push      = 1'b0;
    logic                           full;
    logic [lbgf_pkg::TIME_W-1:0]    time_ms   = '0;
    logic                           empty;
    logic                           pop       = 1'b0;
    logic [lbgf_pkg::IDX_W-1:0]     led_index;
    logic [lbgf_pkg::COLOR_W-1:0]   led_color;
    logic                           last;

    // Shadow registers used by the frame predictor.
    logic [lbgf_pkg::TIME_W-1:0]  scale_ms  = lbgf_pkg::RST_FULL_SCALE;
    logic [lbgf_pkg::CNT_W-1:0]   lit_count = lbgf_pkg::RST_LED_COUNT;
    logic [lbgf_pkg::COLOR_W-1:0] bar_rgb   = lbgf_pkg::RST_BAR_COLOR;

    logic [lbgf_pkg::TIME_W-1:0] time_q[$];
    led_word_t                   led_q[$];

    int  times_offered = 0;
    int  times_taken   = 0;
    int  errors        = 0;
    int  cycles        = 0;
    bit  in_taken      = 1'b0;
    bit  out_taken     = 1'b0;
    bit  brisk         = 1'b0;
    bit  hold_toggle   = 1'b0;
    bit  hold_seen     = 1'b0;
    int  hold_len      = 0;
    int  hold_left     = 0;
    int  send_wait     = 0;
    int  recv_wait     = 0;

    led_bar_graph_fader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .time_ms   (time_ms),
        .empty     (empty),
        .pop       (pop),
        .led_index (led_index),
        .led_color (led_color),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Scales each byte channel by a 0.16 fraction, truncating.
    function automatic logic [lbgf_pkg::COLOR_W-1:0] dim_color(
        input logic [lbgf_pkg::COLOR_W-1:0] c,
        input logic [lbgf_pkg::FRAC_W-1:0]  f);
        logic [lbgf_pkg::COLOR_W-1:0] r;
        logic [23:0]                  prod;
        for (int b = 0; b < 4; b++)
        begin
            prod = c[8*b +: 8] * f;
            r[8*b +: 8] = prod[23:16];
        end
        return r;
    endfunction

    function automatic void predict_frame(input logic [lbgf_pkg::TIME_W-1:0] t);
        logic [lbgf_pkg::CNT_W-1:0] n;
        logic [63:0]                prod;
        logic [63:0]                whole;
        logic [63:0]                frac;
        logic                       dark;
        led_word_t                  w;
        n = (lit_count > lbgf_pkg::CNT_LIMIT) ? lbgf_pkg::CNT_LIMIT : lit_count;
        dark = (scale_ms == 0) || (t > scale_ms);
        whole = 0;
        frac = 0;
        if (!dark)
        begin
            prod = 64'(t) * 64'(n);
            whole = prod / scale_ms;
            frac = ((prod % scale_ms) << 16) / scale_ms;
        end
        for (int i = 0; i < n; i++)
        begin
            w.idx = i[lbgf_pkg::IDX_W-1:0];
            if (dark)
                w.color = '0;
            else if (i < whole)
                w.color = bar_rgb;
            else if (i == whole)
                w.color = dim_color(bar_rgb, frac[lbgf_pkg::FRAC_W-1:0]);
            else
                w.color = '0;
            w.last = (i + 1 == n);
            led_q.push_back(w);
        end
    endfunction

    function automatic logic [lbgf_pkg::TIME_W-1:0] pick_time(
        input logic [lbgf_pkg::TIME_W-1:0] scale);
        logic [lbgf_pkg::TIME_W-1:0] t;
        case ($urandom_range(0, 9))
            6: t = scale;
            7: t = scale + 1;
            8: t = $urandom;
            9: t = scale - $urandom_range(0, 3);
            default: t = $urandom_range(0, scale);
        endcase
        return t;
    endfunction

    task automatic write_reg(input logic [lbgf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbgf_pkg::COLOR_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lbgf_pkg::CFG_FULL_SCALE: scale_ms = data;
            lbgf_pkg::CFG_LED_COUNT:  lit_count = data[lbgf_pkg::CNT_W-1:0];
            lbgf_pkg::CFG_BAR_COLOR:  bar_rgb = data;
            default: ;
        endcase
    endtask

    function automatic void offer(input logic [lbgf_pkg::TIME_W-1:0] t);
        time_q.push_back(t);
        times_offered++;
    endfunction

    // Waits until every offered word is taken and every LED word has come,
    // then lets the block finish any frame that emits nothing.
    task automatic settle();
        while (times_taken != times_offered || led_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : driver
        logic offer_now;
        if (rst_n)
        begin
            offer_now = push && !in_taken;
            if (!offer_now)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (time_q.size() > 0)
                begin
                    time_ms <= time_q.pop_front();
                    offer_now = 1'b1;
                    send_wait = brisk ? 0 : $urandom_range(0, 9);
                end
            end
            push <= offer_now;
        end
    end

    always @(negedge clk)
    begin : receiver
        logic ready;
        if (rst_n)
        begin
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = hold_len;
            end
            if (out_taken)
                recv_wait = brisk ? 0 : $urandom_range(0, 9);
            if (hold_left > 0)
            begin
                hold_left--;
                ready = 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                ready = 1'b0;
            end
            else
                ready = 1'b1;
            pop <= ready;
        end
    end

    always @(posedge clk)
    begin : monitor
        led_word_t want;
        in_taken = push && !full;
        out_taken = pop && !empty;
        if (in_taken)
        begin
            predict_frame(time_ms);
            times_taken++;
        end
        if (out_taken)
        begin
            if (led_q.size() == 0)
            begin
                $error("unexpected LED word: led_index %0d led_color %08h last %0b",
                       led_index, led_color, last);
                errors++;
            end
            else
            begin
                want = led_q.pop_front();
                if (led_index !== want.idx)
                begin
                    $error("led_index: expected %0d, got %0d", want.idx, led_index);
                    errors++;
                end
                if (led_color !== want.color)
                begin
                    $error("led_color: expected %08h, got %08h", want.color, led_color);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("led_bar_graph_fader verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] rnd;
        logic [31:0] fs_pick;
        logic [31:0] cnt_pick;
        logic [31:0] rgb_pick;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Register defaults: empty bar, exact full scale, past full scale, fades.
        offer(0);
        offer(lbgf_pkg::RST_FULL_SCALE);
        offer(lbgf_pkg::RST_FULL_SCALE + 1);
        offer('1);
        offer(750000);
        offer(150000);
        offer(1499999);
        offer(1);
        settle();

        // A zero full scale leaves every LED dark.
        write_reg(lbgf_pkg::CFG_FULL_SCALE, '0);
        offer(0);
        offer(5);
        settle();

        // A zero count gives no words at all.
        write_reg(lbgf_pkg::CFG_FULL_SCALE, 16);
        write_reg(lbgf_pkg::CFG_LED_COUNT, 0);
        offer(8);
        settle();

        // The largest count saturates; the unused index must not touch anything.
        write_reg(lbgf_pkg::CFG_LED_COUNT, 31);
        write_reg(lbgf_pkg::CFG_BAR_COLOR, '1);
        write_reg(CFG_UNUSED, 32'h0000_0001);
        offer(7);
        offer(16);
        offer(17);
        settle();

        write_reg(lbgf_pkg::CFG_FULL_SCALE, '1);
        write_reg(lbgf_pkg::CFG_LED_COUNT, 16);
        offer('1);
        offer(32'hFFFF_FFFE);
        offer(32'h8000_0000);
        settle();

        write_reg(lbgf_pkg::CFG_FULL_SCALE, 1);
        write_reg(lbgf_pkg::CFG_LED_COUNT, 1);
        write_reg(lbgf_pkg::CFG_BAR_COLOR, 32'h80C0_4001);
        offer(0);
        offer(1);
        offer(2);
        settle();

        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 5))
                0: fs_pick = $urandom_range(1, 64);
                1: fs_pick = $urandom_range(1000, 3000000);
                2: fs_pick = $urandom;
                3: fs_pick = '1;
                4: fs_pick = $urandom_range(100, 100000);
                default: fs_pick = $urandom_range(1, 16);
            endcase
            rnd = $urandom;
            case ($urandom_range(0, 9))
                0: cnt_pick = {rnd[31:lbgf_pkg::CNT_W], 5'd0};
                1: cnt_pick = {rnd[31:lbgf_pkg::CNT_W], 5'($urandom_range(17, 31))};
                default: cnt_pick = {rnd[31:lbgf_pkg::CNT_W], 5'($urandom_range(1, 16))};
            endcase
            case ($urandom_range(0, 7))
                0: rgb_pick = '1;
                1: rgb_pick = '0;
                default: rgb_pick = $urandom;
            endcase
            if (ph == 2)
            begin
                // Full frames while the receiver stops for a long stretch, so
                // the block fills up and holds off the sender.
                cnt_pick = 16;
                fs_pick = $urandom_range(1000, 3000000);
                hold_len = 400;
                hold_toggle = !hold_toggle;
            end
            brisk = (ph % 4 == 3);
            write_reg(lbgf_pkg::CFG_FULL_SCALE, fs_pick);
            write_reg(lbgf_pkg::CFG_LED_COUNT, cnt_pick);
            write_reg(lbgf_pkg::CFG_BAR_COLOR, rgb_pick);
            for (int k = 0; k < 21; k++)
                offer(pick_time(fs_pick));
            settle();
        end

        if (errors == 0 && led_q.size() == 0)
            $display("led_bar_graph_fader verification clean");
        else
            $display("led_bar_graph_fader verification failed");
        $finish;
    end
endmodule
